// File: rtl/core/gradient_edge_nms_classifier_top_macros.svh
// Assertion macros shared by the gradient edge classifier RTL.
`ifndef GRADIENT_EDGE_NMS_CLASSIFIER_TOP_MACROS_SVH
`define GRADIENT_EDGE_NMS_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GENMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define GENMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/genms_pkg.sv
// Types and constants shared by the gradient edge classifier modules.
`timescale 1ns / 1ps
`default_nettype none
package genms_pkg;

  localparam int CRD_W = 14;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_EDGE_KIND = 2'd1;
  localparam logic [1:0] CFG_WIDTH     = 2'd2;
  localparam logic [1:0] CFG_HEIGHT    = 2'd3;

  localparam logic signed [1:0] KIND_PLAIN = 2'sb00;

  typedef struct packed {
    logic       operation;
    logic [8:0] column;
    logic [8:0] row;
    logic [15:0] pixel_value;
  } genms_in_t;

  typedef struct packed {
    logic       edge_res;
    logic [8:0] out_column;
    logic [8:0] out_row;
  } genms_out_t;

  typedef struct packed {
    logic [7:0]       threshold;
    logic signed [1:0] edge_kind;
    logic [CRD_W-1:0] width;
    logic [CRD_W-1:0] height;
  } genms_cfg_t;

  typedef struct packed {
    logic emit;
    logic edge_res;
  } genms_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BORDER,
    ST_GRD_RD,
    ST_GRD_SQ,
    ST_GRD_SUM,
    ST_CTR_RD,
    ST_K_TEST,
    ST_RND_X,
    ST_RND_Y,
    ST_SMP_RD,
    ST_SMP_CHK,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_MUL1,
    RS_MUL2,
    RS_PROD,
    RS_CMP,
    RS_DONE
  } rnd_state_t;

endpackage
`default_nettype wire

// File: rtl/core/genms_fmem.sv
// Frame memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module genms_fmem #(
  parameter int AW    = 18,
  parameter int DEPTH = 262144,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/genms_round.sv
// Iterative exact rounding of k*g/sqrt(gs) using integer squares.
`timescale 1ns / 1ps
`default_nettype none
module genms_round #(
  parameter int PIXEL_BITS    = 16,
  parameter int SEARCH_RADIUS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [PIXEL_BITS:0] g,
  input  logic [$clog2(SEARCH_RADIUS+2)-1:0] k,
  input  logic [2*PIXEL_BITS:0] gs,
  output logic done,
  output logic signed [$clog2(SEARCH_RADIUS+2):0] n
);
  import genms_pkg::*;

  localparam int P   = PIXEL_BITS;
  localparam int KW  = $clog2(SEARCH_RADIUS + 2);
  localparam int A2W = $clog2((2 * SEARCH_RADIUS + 1) * (2 * SEARCH_RADIUS + 1) + 1);
  localparam int BW  = P + KW + 1;
  localparam int BBW = 2 * BW;
  localparam int PW  = A2W + 2 * P + 1;
  localparam int CW  = (BBW > PW) ? BBW : PW;

  rnd_state_t state_r, state_nxt;

  logic                 neg_r;
  logic [P-1:0]         gabs_r;
  logic [KW-1:0]        k_r;
  logic [2*P:0]         gs_r;
  logic [BW-1:0]        b_r;
  logic [BBW-1:0]       bb_r;
  logic signed [KW:0]   n_r;
  logic signed [KW+1:0] a_r;
  logic [A2W-1:0]       a2_r;
  logic [PW-1:0]        prod_r;

  logic [P+KW-1:0]      gk;
  logic signed [KW+1:0] a_init;
  logic [KW+1:0]        a_init_u;
  logic signed [A2W+1:0] a2_upd;
  logic signed [KW:0]   n_dec;
  logic                 ok;
  logic                 at_limit;

  assign gk       = (P + KW)'(gabs_r) * (P + KW)'(k_r);
  assign a_init   = $signed({1'b0, k_r, 1'b0}) - (KW + 2)'(1);
  assign a_init_u = $unsigned(a_init);
  assign a2_upd   = $signed({2'b00, a2_r}) - ((A2W + 2)'(a_r) <<< 2) + (A2W + 2)'(4);
  assign n_dec    = n_r - (KW + 1)'(1);
  assign ok       = neg_r ? (CW'(prod_r) >= CW'(bb_r)) : (CW'(prod_r) <= CW'(bb_r));
  assign at_limit = neg_r ? (n_dec == -$signed({1'b0, k_r})) : (n_dec == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      RS_IDLE: begin
        if (start) state_nxt = RS_MUL1;
      end
      RS_MUL1: state_nxt = RS_MUL2;
      RS_MUL2: state_nxt = RS_PROD;
      RS_PROD: state_nxt = RS_CMP;
      RS_CMP: begin
        if (ok || at_limit) state_nxt = RS_DONE;
        else state_nxt = RS_PROD;
      end
      RS_DONE: begin
        if (start) state_nxt = RS_MUL1;
        else state_nxt = RS_IDLE;
      end
      default: state_nxt = RS_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == RS_DONE);
    n    = n_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= g[P];
      gabs_r <= P'(g[P] ? -g : g);
      k_r    <= k;
      gs_r   <= gs;
    end
    case (state_r)
      RS_MUL1: begin
        b_r <= {gk, 1'b0};
        if (neg_r) begin
          n_r  <= '0;
          a_r  <= -(KW + 2)'(1);
          a2_r <= A2W'(1);
        end else begin
          n_r  <= $signed({1'b0, k_r});
          a_r  <= a_init;
          a2_r <= A2W'(a_init_u * a_init_u);
        end
      end
      RS_MUL2: bb_r <= BBW'(b_r) * BBW'(b_r);
      RS_PROD: prod_r <= PW'(a2_r) * PW'(gs_r);
      RS_CMP: begin
        if (!ok) begin
          n_r  <= n_dec;
          a_r  <= a_r - (KW + 2)'(2);
          a2_r <= A2W'(a2_upd);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/genms_ctrl.sv
// Query sequencer: gradients, suppression test and tangent search over the frame.
`timescale 1ns / 1ps
`default_nettype none
module genms_ctrl #(
  parameter int PIXEL_BITS    = 16,
  parameter int SEARCH_RADIUS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [8:0]                      qx,
  input  logic [8:0]                      qy,
  input  genms_pkg::genms_cfg_t           cfg,
  input  logic                            out_free,
  output logic                            busy,
  output logic signed [genms_pkg::CRD_W-1:0] rd_x,
  output logic signed [genms_pkg::CRD_W-1:0] rd_y,
  input  logic [PIXEL_BITS-1:0]           rd_data,
  output genms_pkg::genms_res_t           res
);
  import genms_pkg::*;

  localparam int P  = PIXEL_BITS;
  localparam int KW = $clog2(SEARCH_RADIUS + 2);
  localparam int BW = ((P > 15) ? P : 15) + 2;
  localparam logic signed [CRD_W-1:0] C_ONE = CRD_W'(1);
  localparam logic signed [CRD_W-1:0] C_TWO = CRD_W'(2);
  localparam logic signed [CRD_W-1:0] C_RAD = CRD_W'(SEARCH_RADIUS);

  ctrl_state_t state_r, state_nxt;

  logic signed [CRD_W-1:0] x_r, y_r;
  logic [1:0]              phase_r;
  logic [2:0]              rd_cnt_r;
  logic [P-1:0]            pa_r;
  logic signed [P:0]       gxt_r, gyt_r, gx_r, gy_r;
  logic [2*P-1:0]          sqx_r, sqy_r;
  logic [2*P:0]            g0_r;
  logic                    axis_r;
  logic [31:0]             tsq_r;
  logic signed [BW-1:0]    chi_r, clo_r;
  logic [KW-1:0]           reach_r, k_r;
  logic signed [3:0]       cnt_r;
  logic signed [KW:0]      rx_r, ry_r;
  logic                    res_edge_r;

  logic signed [CRD_W-1:0] w_s, h_s, offx, offy, bx, by, rx_ext, ry_ext;
  logic signed [CRD_W-1:0] rch0, rch1, rch2, rch3;
  logic [P-1:0]            gxa, gya;
  logic [2*P:0]            gsum;
  logic                    thr_fail, nb_fail, at_border, k_over, cnt_out, fin_res;
  logic signed [BW-1:0]    sv;
  logic signed [3:0]       delta;
  logic                    rnd_start, rnd_done;
  logic signed [P:0]       rnd_g;
  logic signed [KW:0]      rnd_n;

  assign w_s  = $signed(cfg.width);
  assign h_s  = $signed(cfg.height);
  assign gxa  = P'(gxt_r[P] ? -gxt_r : gxt_r);
  assign gya  = P'(gyt_r[P] ? -gyt_r : gyt_r);
  assign gsum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign thr_fail = 34'(gsum) <= 34'(tsq_r);
  assign nb_fail  = gsum > g0_r;
  assign at_border = (x_r < C_TWO) || (y_r < C_TWO) ||
                     (x_r >= w_s - C_TWO) || (y_r >= h_s - C_TWO);
  assign k_over  = k_r > reach_r;
  assign cnt_out = (cnt_r > 4'sd2) || (cnt_r < -4'sd2);
  assign fin_res = cfg.edge_kind[1] ? (cnt_r > 4'sd2) : (cnt_r < -4'sd2);
  assign sv      = $signed(BW'(rd_data));
  assign delta   = (sv > chi_r) ? 4'sd1 : ((sv < clo_r) ? -4'sd1 : 4'sd0);
  assign rx_ext  = CRD_W'(rx_r);
  assign ry_ext  = CRD_W'(ry_r);

  always_comb begin
    rch0 = (x_r < C_RAD) ? x_r : C_RAD;
    rch1 = (w_s - C_ONE - x_r < rch0) ? (w_s - C_ONE - x_r) : rch0;
    rch2 = (y_r < rch1) ? y_r : rch1;
    rch3 = (h_s - C_ONE - y_r < rch2) ? (h_s - C_ONE - y_r) : rch2;
  end

  always_comb begin
    offx = '0;
    offy = '0;
    if (phase_r == 2'd1) begin
      if (axis_r) offx = C_ONE;
      else offy = C_ONE;
    end else if (phase_r == 2'd2) begin
      if (axis_r) offx = -C_ONE;
      else offy = -C_ONE;
    end
    bx = x_r + offx;
    by = y_r + offy;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_BORDER;
      end
      ST_BORDER: begin
        if (at_border) state_nxt = ST_DONE;
        else state_nxt = ST_GRD_RD;
      end
      ST_GRD_RD: begin
        if (rd_cnt_r == 3'd4) state_nxt = ST_GRD_SQ;
      end
      ST_GRD_SQ: state_nxt = ST_GRD_SUM;
      ST_GRD_SUM: begin
        if (phase_r == 2'd0) begin
          state_nxt = thr_fail ? ST_DONE : ST_GRD_RD;
        end else if (phase_r == 2'd1) begin
          state_nxt = nb_fail ? ST_DONE : ST_GRD_RD;
        end else if (nb_fail || cfg.edge_kind == KIND_PLAIN) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CTR_RD;
        end
      end
      ST_CTR_RD: begin
        if (rd_cnt_r == 3'd1) state_nxt = ST_K_TEST;
      end
      ST_K_TEST: begin
        if (k_over) state_nxt = ST_DONE;
        else state_nxt = ST_RND_X;
      end
      ST_RND_X: begin
        if (rnd_done) state_nxt = ST_RND_Y;
      end
      ST_RND_Y: begin
        if (rnd_done) state_nxt = ST_SMP_RD;
      end
      ST_SMP_RD: begin
        if (rd_cnt_r == 3'd2) state_nxt = ST_SMP_CHK;
      end
      ST_SMP_CHK: begin
        if (cnt_out) state_nxt = ST_DONE;
        else state_nxt = ST_K_TEST;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state_r != ST_IDLE);
    res.emit     = (state_r == ST_DONE) && out_free;
    res.edge_res = res_edge_r;
    rnd_start    = ((state_r == ST_K_TEST) && !k_over) || ((state_r == ST_RND_X) && rnd_done);
    rnd_g        = (state_r == ST_K_TEST) ? gx_r : gy_r;
    rd_x         = x_r;
    rd_y         = y_r;
    case (state_r)
      ST_GRD_RD: begin
        case (rd_cnt_r)
          3'd0: begin rd_x = bx + C_ONE; rd_y = by; end
          3'd1: begin rd_x = bx - C_ONE; rd_y = by; end
          3'd2: begin rd_x = bx; rd_y = by + C_ONE; end
          default: begin rd_x = bx; rd_y = by - C_ONE; end
        endcase
      end
      ST_SMP_RD: begin
        if (rd_cnt_r == 3'd0) begin
          rd_x = x_r + ry_ext;
          rd_y = y_r - rx_ext;
        end else begin
          rd_x = x_r - ry_ext;
          rd_y = y_r + rx_ext;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tsq_r <= {16'(cfg.threshold) * 16'(cfg.threshold), 16'b0};
    case (state_r)
      ST_IDLE: begin
        x_r      <= $signed(CRD_W'(qx));
        y_r      <= $signed(CRD_W'(qy));
        phase_r  <= 2'd0;
        rd_cnt_r <= 3'd0;
      end
      ST_BORDER: begin
        res_edge_r <= 1'b0;
        rd_cnt_r   <= 3'd0;
      end
      ST_GRD_RD: begin
        rd_cnt_r <= rd_cnt_r + 3'd1;
        case (rd_cnt_r)
          3'd1: pa_r <= rd_data;
          3'd2: gxt_r <= $signed({1'b0, pa_r}) - $signed({1'b0, rd_data});
          3'd3: pa_r <= rd_data;
          3'd4: gyt_r <= $signed({1'b0, pa_r}) - $signed({1'b0, rd_data});
          default: ;
        endcase
      end
      ST_GRD_SQ: begin
        sqx_r <= (2 * P)'(gxa) * (2 * P)'(gxa);
        sqy_r <= (2 * P)'(gya) * (2 * P)'(gya);
      end
      ST_GRD_SUM: begin
        rd_cnt_r   <= 3'd0;
        phase_r    <= phase_r + 2'd1;
        res_edge_r <= (phase_r == 2'd2) && !nb_fail;
        if (phase_r == 2'd0) begin
          g0_r   <= gsum;
          gx_r   <= gxt_r;
          gy_r   <= gyt_r;
          axis_r <= gxa > gya;
        end
      end
      ST_CTR_RD: begin
        rd_cnt_r <= rd_cnt_r + 3'd1;
        if (rd_cnt_r == 3'd1) begin
          chi_r   <= $signed(BW'(rd_data)) + $signed(BW'({cfg.threshold, 7'b0}));
          clo_r   <= $signed(BW'(rd_data)) - $signed(BW'({cfg.threshold, 7'b0}));
          reach_r <= KW'(rch3);
          k_r     <= KW'(1);
          cnt_r   <= 4'sd0;
        end
      end
      ST_K_TEST: res_edge_r <= fin_res;
      ST_RND_X: begin
        if (rnd_done) rx_r <= rnd_n;
      end
      ST_RND_Y: begin
        rd_cnt_r <= 3'd0;
        if (rnd_done) ry_r <= rnd_n;
      end
      ST_SMP_RD: begin
        rd_cnt_r <= rd_cnt_r + 3'd1;
        if (rd_cnt_r != 3'd0) cnt_r <= cnt_r + delta;
      end
      ST_SMP_CHK: begin
        k_r        <= k_r + KW'(1);
        res_edge_r <= fin_res;
      end
      default: ;
    endcase
  end

  genms_round #(
    .PIXEL_BITS   (PIXEL_BITS),
    .SEARCH_RADIUS(SEARCH_RADIUS)
  ) u_round (
    .clk  (clk),
    .rst_n(rst_n),
    .start(rnd_start),
    .g    (rnd_g),
    .k    (k_r),
    .gs   (g0_r),
    .done (rnd_done),
    .n    (rnd_n)
  );

endmodule
`default_nettype wire

// File: rtl/core/gradient_edge_nms_classifier_top.sv
// Top level of the gradient edge classifier with non-maximum suppression.
// The input channel carries write and query transfers. A write stores one
// pixel in the frame memory in the cycle it is accepted and gives no result.
// A query yields one result transfer with the edge bit and the echoed
// coordinates. Queries are processed one at a time; the input is stalled
// while a query is in progress. A query inside the two-pixel border ends
// with no pixel reads; a full plain-edge decision makes twelve pixel reads
// through the single read port of the frame memory. In light or dark mode
// each tangent step adds two iterative rounding passes, which test candidate
// offsets one by one, and two sample reads, for up to SEARCH_RADIUS steps.
// The finished result sits in an output register; a new item is accepted
// while that result waits for a stalled receiver. A query that finishes
// while the previous result is still stalled waits until it is taken.
// Reset clears the control state and loads the register defaults; the frame
// memory holds no defined content until written.
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_edge_nms_classifier_top_macros.svh"
module gradient_edge_nms_classifier_top #(
  parameter int MAX_WIDTH     = 512,
  parameter int MAX_HEIGHT    = 512,
  parameter int SEARCH_RADIUS = 8,
  parameter int PIXEL_BITS    = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  genms_pkg::genms_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output genms_pkg::genms_out_t  out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [9:0]             cfg_wdata
);
  import genms_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]        thr_r;
  logic signed [1:0] kind_r;
  logic [9:0]        iw_r, ih_r;
  logic              out_valid_r;
  genms_out_t        out_data_r;
  logic [8:0]        qcol_r, qrow_r;

  logic              in_xfer, start, mem_we, out_free, busy;
  logic [CRD_W-1:0]  iw_ext, ih_ext;
  genms_cfg_t        cfg;
  genms_res_t        ctrl_res;
  logic signed [CRD_W-1:0] rd_x, rd_y;
  logic [AW-1:0]     waddr, raddr;
  logic [PIXEL_BITS-1:0] rdata;

  assign in_xfer  = in_valid && !in_stall;
  assign start    = in_xfer && (in_data.operation == OP_QUERY);
  assign mem_we   = in_xfer && (in_data.operation == OP_WRITE) &&
                    (CRD_W'(in_data.column) < CRD_W'(MAX_WIDTH)) &&
                    (CRD_W'(in_data.row) < CRD_W'(MAX_HEIGHT));
  assign in_stall = busy;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign iw_ext = CRD_W'(iw_r);
  assign ih_ext = CRD_W'(ih_r);
  always_comb begin
    cfg.threshold = thr_r;
    cfg.edge_kind = kind_r;
    cfg.width     = (iw_ext > CRD_W'(MAX_WIDTH)) ? CRD_W'(MAX_WIDTH) : iw_ext;
    cfg.height    = (ih_ext > CRD_W'(MAX_HEIGHT)) ? CRD_W'(MAX_HEIGHT) : ih_ext;
  end

  assign waddr = AW'(AW'(in_data.row) * AW'(MAX_WIDTH)) + AW'(in_data.column);
  assign raddr = AW'(AW'($unsigned(rd_y)) * AW'(MAX_WIDTH)) + AW'($unsigned(rd_x));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 8'd32;
      kind_r <= KIND_PLAIN;
      iw_r   <= 10'd512;
      ih_r   <= 10'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r  <= cfg_wdata[7:0];
        CFG_EDGE_KIND: kind_r <= $signed(cfg_wdata[1:0]);
        CFG_WIDTH:     iw_r   <= cfg_wdata;
        CFG_HEIGHT:    ih_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qcol_r <= in_data.column;
      qrow_r <= in_data.row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl_res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_res.emit) begin
      out_data_r.edge_res   <= ctrl_res.edge_res;
      out_data_r.out_column <= qcol_r;
      out_data_r.out_row    <= qrow_r;
    end
  end

  genms_fmem #(
    .AW   (AW),
    .DEPTH(DEPTH),
    .DW   (PIXEL_BITS)
  ) u_fmem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(waddr),
    .wdata(in_data.pixel_value[PIXEL_BITS-1:0]),
    .raddr(raddr),
    .rdata(rdata)
  );

  genms_ctrl #(
    .PIXEL_BITS   (PIXEL_BITS),
    .SEARCH_RADIUS(SEARCH_RADIUS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .qx      (in_data.column),
    .qy      (in_data.row),
    .cfg     (cfg),
    .out_free(out_free),
    .busy    (busy),
    .rd_x    (rd_x),
    .rd_y    (rd_y),
    .rd_data (rdata),
    .res     (ctrl_res)
  );

  `GENMS_ASSERT_NEXT(a_query_holds_input, start, in_stall, "query transfer did not stall input")
  `GENMS_ASSERT_NOW(a_no_result_overwrite, ctrl_res.emit, out_free, "result overwrote held output")
  `GENMS_ASSERT_NOW(a_emit_while_busy, ctrl_res.emit, in_stall, "result emitted while idle")

endmodule
`default_nettype wire
